### rtl/core/tlfs_pkg.sv
// tlfs_pkg: types and constants of the two-level feedback scheduler
// transaction payloads, event kinds, configuration indexes and controller states
// no dependencies
`timescale 1ns / 1ps

package tlfs_pkg;

  localparam int unsigned IdFieldW = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned KindW    = 3;
  localparam int unsigned ElapsedW = 17;

  // event kinds
  localparam logic [KindW-1:0] KIND_ADD        = 3'd0;
  localparam logic [KindW-1:0] KIND_TICK       = 3'd1;
  localparam logic [KindW-1:0] KIND_FINISH     = 3'd2;
  localparam logic [KindW-1:0] KIND_BLOCK      = 3'd3;
  localparam logic [KindW-1:0] KIND_NOTIFY_ONE = 3'd4;
  localparam logic [KindW-1:0] KIND_NOTIFY_ALL = 3'd5;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FIRST_QUANTUM  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SECOND_QUANTUM = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TICK_INTERVAL  = 2'd2;

  localparam logic [CfgDataW-1:0] FIRST_QUANTUM_RST  = 16'd4;
  localparam logic [CfgDataW-1:0] SECOND_QUANTUM_RST = 16'd8;
  localparam logic [CfgDataW-1:0] TICK_INTERVAL_RST  = 16'd1;

  typedef struct packed {
    logic [KindW-1:0]    kind;
    logic [IdFieldW-1:0] thread_id;
  } in_t;

  typedef struct packed {
    logic [IdFieldW-1:0] running_thread;
    logic                running_idle;
    logic                running_level;
    logic                event_error;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TAKE,
    S_MOVE,
    S_DRAIN,
    S_RESP
  } state_e;

endpackage

### rtl/core/tlfs_ram.sv
// tlfs_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module tlfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/two_level_feedback_scheduler_core.sv
// add, tick without switch, block and idle choice go through states exec and resp;
// a take state follows exec where a thread is taken from a ready queue (ram read);
// notify-one and notify-all go through move, notify-all alternating drain and move per
// blocked entry (read then write); one event at a time, the result may wait on out_ready_i
// reset: queues empty, idle thread running, quanta 4 and 8, tick interval 1
`timescale 1ns / 1ps

module two_level_feedback_scheduler_core #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tlfs_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [tlfs_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  tlfs_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output tlfs_pkg::out_t                     out_data_o
);

  import tlfs_pkg::*;

  localparam int unsigned PtrW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IdWideW = (ID_BITS > IdFieldW) ? ID_BITS : IdFieldW;

  typedef struct packed {
    logic [PtrW-1:0] head;
    logic [PtrW-1:0] tail;
    logic [CntW-1:0] cnt;
  } fifo_ptr_t;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  function automatic fifo_ptr_t fifo_push(input fifo_ptr_t f);
    fifo_ptr_t r;
    r      = f;
    r.tail = ptr_inc(f.tail);
    r.cnt  = f.cnt + 1'b1;
    return r;
  endfunction

  function automatic fifo_ptr_t fifo_pop(input fifo_ptr_t f);
    fifo_ptr_t r;
    r      = f;
    r.head = ptr_inc(f.head);
    r.cnt  = f.cnt - 1'b1;
    return r;
  endfunction

  // configuration
  logic [CfgDataW-1:0] first_q_q, second_q_q, interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q_q  <= FIRST_QUANTUM_RST;
      second_q_q <= SECOND_QUANTUM_RST;
      interval_q <= TICK_INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIRST_QUANTUM:  first_q_q  <= cfg_data_i;
        CFG_SECOND_QUANTUM: second_q_q <= cfg_data_i;
        CFG_TICK_INTERVAL:  interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // scheduler state
  state_e               state_q, state_d;
  fifo_ptr_t            hi_q, hi_d, lo_q, lo_d, bk_q, bk_d;
  logic [ID_BITS-1:0]   cur_id_q, cur_id_d;
  logic                 cur_idle_q, cur_idle_d;
  logic                 cur_lvl_q, cur_lvl_d;
  logic [ElapsedW-1:0]  elapsed_q, elapsed_d;
  logic [KindW-1:0]     kind_q, kind_d;
  logic [ID_BITS-1:0]   tid_q, tid_d;
  logic                 err_q, err_d;
  logic                 src_low_q, src_low_d;
  logic                 swap_q, swap_d;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_q, out_d;

  // ram ports
  logic               hi_we, lo_we, bk_we;
  logic [ID_BITS-1:0] hi_wdata, lo_wdata, bk_wdata;
  logic [ID_BITS-1:0] hi_rdata, lo_rdata, bk_rdata;

  tlfs_ram #(.WIDTH(ID_BITS), .DEPTH(QUEUE_DEPTH)) u_hi_ram (
    .clk_i   (clk_i),
    .we_i    (hi_we),
    .waddr_i (hi_q.tail),
    .wdata_i (hi_wdata),
    .raddr_i (hi_q.head),
    .rdata_o (hi_rdata)
  );

  tlfs_ram #(.WIDTH(ID_BITS), .DEPTH(QUEUE_DEPTH)) u_lo_ram (
    .clk_i   (clk_i),
    .we_i    (lo_we),
    .waddr_i (lo_q.tail),
    .wdata_i (lo_wdata),
    .raddr_i (lo_q.head),
    .rdata_o (lo_rdata)
  );

  tlfs_ram #(.WIDTH(ID_BITS), .DEPTH(QUEUE_DEPTH)) u_bk_ram (
    .clk_i   (clk_i),
    .we_i    (bk_we),
    .waddr_i (bk_q.tail),
    .wdata_i (bk_wdata),
    .raddr_i (bk_q.head),
    .rdata_o (bk_rdata)
  );

  logic [IdWideW-1:0]  tid_wide, cur_wide;
  logic                hi_full, lo_full, bk_full, hi_any, lo_any, bk_any;
  logic                sw_fail, want_choose, want_switch;
  logic [ElapsedW:0]   sum;
  logic [ElapsedW-1:0] e_sat;
  logic [CfgDataW-1:0] quantum;
  logic                expired;
  logic [CntW:0]       merged;

  assign tid_wide = IdWideW'(in_data_i.thread_id);
  assign cur_wide = IdWideW'(cur_id_q);

  assign hi_full = (hi_q.cnt == CntW'(QUEUE_DEPTH));
  assign lo_full = (lo_q.cnt == CntW'(QUEUE_DEPTH));
  assign bk_full = (bk_q.cnt == CntW'(QUEUE_DEPTH));
  assign hi_any  = (hi_q.cnt != '0);
  assign lo_any  = (lo_q.cnt != '0);
  assign bk_any  = (bk_q.cnt != '0);
  assign merged  = {1'b0, hi_q.cnt} + {1'b0, bk_q.cnt};

  // switching to high-level work needs room for the preempted thread
  assign sw_fail = hi_any && lo_full;

  // elapsed ticks saturate at the all-ones value
  assign sum     = {1'b0, elapsed_q} + (ElapsedW + 1)'(interval_q);
  assign e_sat   = sum[ElapsedW] ? '1 : sum[ElapsedW-1:0];
  assign quantum = cur_lvl_q ? second_q_q : first_q_q;
  assign expired = (e_sat >= ElapsedW'(quantum));

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    bk_d        = bk_q;
    cur_id_d    = cur_id_q;
    cur_idle_d  = cur_idle_q;
    cur_lvl_d   = cur_lvl_q;
    elapsed_d   = elapsed_q;
    kind_d      = kind_q;
    tid_d       = tid_q;
    err_d       = err_q;
    src_low_d   = src_low_q;
    swap_d      = swap_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    hi_we       = 1'b0;
    lo_we       = 1'b0;
    bk_we       = 1'b0;
    hi_wdata    = tid_q;
    lo_wdata    = cur_id_q;
    bk_wdata    = cur_id_q;
    want_choose = 1'b0;
    want_switch = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = in_data_i.kind;
          tid_d   = tid_wide[ID_BITS-1:0];
          err_d   = 1'b0;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_RESP;
        unique case (kind_q)
          KIND_ADD: begin
            if (hi_full) begin
              err_d = 1'b1;
            end else begin
              hi_we = 1'b1;
              hi_d  = fifo_push(hi_q);
            end
          end
          KIND_TICK: begin
            if (cur_idle_q) begin
              want_choose = 1'b1;
            end else if (cur_lvl_q && hi_any) begin
              want_switch = 1'b1;
              if (!sw_fail) begin
                elapsed_d = '0;
              end
            end else if (expired) begin
              want_switch = 1'b1;
              if (!sw_fail) begin
                elapsed_d = e_sat - ElapsedW'(quantum);
              end
            end else begin
              elapsed_d = e_sat;
            end
          end
          KIND_FINISH: begin
            want_choose = 1'b1;
          end
          KIND_BLOCK: begin
            if (cur_idle_q || bk_full) begin
              err_d = 1'b1;
            end else begin
              bk_we       = 1'b1;
              bk_d        = fifo_push(bk_q);
              want_choose = 1'b1;
            end
          end
          KIND_NOTIFY_ONE: begin
            if (!bk_any || hi_full) begin
              err_d = 1'b1;
            end else begin
              bk_d    = fifo_pop(bk_q);
              state_d = S_MOVE;
            end
          end
          KIND_NOTIFY_ALL: begin
            if (!bk_any || (merged > (CntW + 1)'(QUEUE_DEPTH))) begin
              err_d = 1'b1;
            end else begin
              bk_d    = fifo_pop(bk_q);
              state_d = S_MOVE;
            end
          end
          default: begin
            err_d = 1'b1;
          end
        endcase

        if (want_choose) begin
          elapsed_d = '0;
          if (hi_any) begin
            hi_d      = fifo_pop(hi_q);
            src_low_d = 1'b0;
            swap_d    = 1'b0;
            state_d   = S_TAKE;
          end else if (lo_any) begin
            lo_d      = fifo_pop(lo_q);
            src_low_d = 1'b1;
            swap_d    = 1'b0;
            state_d   = S_TAKE;
          end else begin
            cur_id_d   = '0;
            cur_idle_d = 1'b1;
            cur_lvl_d  = 1'b0;
          end
        end

        // with both ready queues empty the running thread keeps going
        if (want_switch) begin
          if (sw_fail) begin
            err_d = 1'b1;
          end else if (hi_any) begin
            hi_d      = fifo_pop(hi_q);
            src_low_d = 1'b0;
            swap_d    = 1'b1;
            state_d   = S_TAKE;
          end else if (lo_any) begin
            lo_d      = fifo_pop(lo_q);
            src_low_d = 1'b1;
            swap_d    = 1'b1;
            state_d   = S_TAKE;
          end
        end
      end

      S_TAKE: begin
        // the popped id arrives from the ram; on a switch the old thread goes to the low queue
        cur_id_d   = src_low_q ? lo_rdata : hi_rdata;
        cur_idle_d = 1'b0;
        cur_lvl_d  = src_low_q;
        if (swap_q) begin
          lo_we = 1'b1;
          lo_d  = fifo_push(lo_q);
        end
        state_d = S_RESP;
      end

      S_MOVE: begin
        hi_we    = 1'b1;
        hi_wdata = bk_rdata;
        hi_d     = fifo_push(hi_q);
        if ((kind_q == KIND_NOTIFY_ALL) && bk_any) begin
          state_d = S_DRAIN;
        end else begin
          state_d = S_RESP;
        end
      end

      S_DRAIN: begin
        bk_d    = fifo_pop(bk_q);
        state_d = S_MOVE;
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.running_thread = cur_idle_q ? '0 : cur_wide[IdFieldW-1:0];
          out_d.running_idle   = cur_idle_q;
          out_d.running_level  = cur_idle_q ? 1'b0 : cur_lvl_q;
          out_d.event_error    = err_q;
          state_d              = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hi_q        <= '0;
      lo_q        <= '0;
      bk_q        <= '0;
      cur_id_q    <= '0;
      cur_idle_q  <= 1'b1;
      cur_lvl_q   <= 1'b0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hi_q        <= hi_d;
      lo_q        <= lo_d;
      bk_q        <= bk_d;
      cur_id_q    <= cur_id_d;
      cur_idle_q  <= cur_idle_d;
      cur_lvl_q   <= cur_lvl_d;
      elapsed_q   <= elapsed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    tid_q     <= tid_d;
    err_q     <= err_d;
    src_low_q <= src_low_d;
    swap_q    <= swap_d;
    out_q     <= out_d;
  end

endmodule
